FILE: src/les_pkg.sv
`default_nettype none

package les_pkg;

    // Fixed-point format of the coordinates
    localparam int FRAC_BITS = 24;
    localparam int COORD_W   = 32;

    // Step size: unsigned Q0.24
    localparam int H_W    = 24;
    localparam int H_FRAC = 24;

    // Multiplier: one signed 32 x 32 unit
    localparam int MUL_W  = 32;
    localparam int PROD_W = 2 * MUL_W;

    // Derivative, increment and sum widths (hold every value exactly)
    localparam int D_W   = 68 - FRAC_BITS;
    localparam int INC_W = D_W + 1;
    localparam int SUM_W = D_W + 2;

    // Model constants
    localparam int SIGMA = 10;
    localparam int RHO   = 28;
    localparam logic [H_W-1:0] H_RESET = H_W'(167772);
    localparam logic signed [COORD_W-1:0] COORD_RESET =
        COORD_W'(((64'd6 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic signed [COORD_W-1:0] BETA_FIX =
        COORD_W'(((64'd8 << FRAC_BITS) + 64'd1) / 64'd3);

    // Request kinds
    typedef enum logic [1:0] {
        REQ_STEP        = 2'd0,
        REQ_LOAD_X_STEP = 2'd1,
        REQ_LOAD_Y      = 2'd2,
        REQ_LOAD_Z      = 2'd3
    } t_req_type;

    // Multiplier operand pairs
    typedef enum logic [3:0] {
        MUL_NONE,
        MUL_XZ,
        MUL_XY,
        MUL_BZ,
        MUL_HI_X,
        MUL_LO_X,
        MUL_HI_Y,
        MUL_LO_Y,
        MUL_HI_Z,
        MUL_LO_Z
    } t_mul_sel;

    // Use of the product registered in the previous cycle
    typedef enum logic [3:0] {
        OP_NONE,
        OP_DXY,
        OP_DZ_SET,
        OP_DZ_SUB,
        OP_X_HI,
        OP_X_FIN,
        OP_Y_HI,
        OP_Y_FIN,
        OP_Z_HI,
        OP_Z_FIN
    } t_prod_op;

    // Controller to datapath command
    typedef struct packed {
        logic      load_en;
        t_req_type load_kind;
        t_mul_sel  mul_sel;
        t_prod_op  prod_op;
        logic      out_load;
    } t_dp_cmd;

    // Channel payloads
    typedef struct packed {
        t_req_type                  req_type;
        logic signed [COORD_W-1:0]  load_value;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] x_out;
        logic signed [COORD_W-1:0] y_out;
        logic signed [COORD_W-1:0] z_out;
    } t_out_item;

endpackage

`default_nettype wire

FILE: src/les_ctrl.sv
`default_nettype none

module les_ctrl (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    input  wire les_pkg::t_req_type i_req_type,
    input  wire logic               i_out_free,
    output logic                    o_in_stall,
    output les_pkg::t_dp_cmd        o_cmd
);
    import les_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_XZ,
        ST_MUL_XY,
        ST_MUL_BZ,
        ST_MUL_HX,
        ST_MUL_LX,
        ST_MUL_HY,
        ST_MUL_LY,
        ST_MUL_HZ,
        ST_MUL_LZ,
        ST_FIN_Z,
        ST_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    // Take a transaction only when idle
    assign o_in_stall = (r_state != ST_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;

    // Sequence the shared multiplier and the datapath operations
    always_comb begin
        n_state         = r_state;
        o_cmd.load_en   = 1'b0;
        o_cmd.load_kind = i_req_type;
        o_cmd.mul_sel   = MUL_NONE;
        o_cmd.prod_op   = OP_NONE;
        o_cmd.out_load  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    o_cmd.load_en = 1'b1;
                    if (i_req_type inside {REQ_STEP, REQ_LOAD_X_STEP}) begin
                        n_state = ST_MUL_XZ;
                    end
                end
            end
            ST_MUL_XZ: begin
                o_cmd.mul_sel = MUL_XZ;
                n_state       = ST_MUL_XY;
            end
            ST_MUL_XY: begin
                o_cmd.mul_sel = MUL_XY;
                o_cmd.prod_op = OP_DXY;
                n_state       = ST_MUL_BZ;
            end
            ST_MUL_BZ: begin
                o_cmd.mul_sel = MUL_BZ;
                o_cmd.prod_op = OP_DZ_SET;
                n_state       = ST_MUL_HX;
            end
            ST_MUL_HX: begin
                o_cmd.mul_sel = MUL_HI_X;
                o_cmd.prod_op = OP_DZ_SUB;
                n_state       = ST_MUL_LX;
            end
            ST_MUL_LX: begin
                o_cmd.mul_sel = MUL_LO_X;
                o_cmd.prod_op = OP_X_HI;
                n_state       = ST_MUL_HY;
            end
            ST_MUL_HY: begin
                o_cmd.mul_sel = MUL_HI_Y;
                o_cmd.prod_op = OP_X_FIN;
                n_state       = ST_MUL_LY;
            end
            ST_MUL_LY: begin
                o_cmd.mul_sel = MUL_LO_Y;
                o_cmd.prod_op = OP_Y_HI;
                n_state       = ST_MUL_HZ;
            end
            ST_MUL_HZ: begin
                o_cmd.mul_sel = MUL_HI_Z;
                o_cmd.prod_op = OP_Y_FIN;
                n_state       = ST_MUL_LZ;
            end
            ST_MUL_LZ: begin
                o_cmd.mul_sel = MUL_LO_Z;
                o_cmd.prod_op = OP_Z_HI;
                n_state       = ST_FIN_Z;
            end
            ST_FIN_Z: begin
                o_cmd.prod_op = OP_Z_FIN;
                n_state       = ST_DONE;
            end
            ST_DONE: begin
                // Hold the result until the output register is free
                if (i_out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // A step request starts the multiply sequence
    a_step_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_STEP || i_req_type == REQ_LOAD_X_STEP))
        |=> (r_state == ST_MUL_XZ))
        else $error("step transaction did not start the sequence");

    // A load of y or z leaves the controller idle
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (i_req_type == REQ_LOAD_Y || i_req_type == REQ_LOAD_Z))
        |=> (r_state == ST_IDLE))
        else $error("load transaction left the controller busy");

    // A finished step waits while the output register is occupied
    a_done_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && !i_out_free) |=> (r_state == ST_DONE))
        else $error("result dropped while output was occupied");

endmodule

`default_nettype wire

FILE: src/les_datapath.sv
`default_nettype none

module les_datapath (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire les_pkg::t_dp_cmd                       i_cmd,
    input  wire logic signed [les_pkg::COORD_W-1:0]     i_load_value,
    input  wire logic                                   i_cfg_we,
    input  wire logic [les_pkg::H_W-1:0]                i_cfg_data,
    input  wire logic                                   i_out_stall,
    output logic                                        o_out_free,
    output logic                                        o_out_valid,
    output les_pkg::t_out_item                          o_out
);
    import les_pkg::*;

    localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2147483647);
    localparam logic signed [SUM_W-1:0] SAT_LO = -SAT_HI - SUM_W'(1);

    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_z;
    logic [H_W-1:0]            r_h;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [D_W-1:0]     r_dx;
    logic signed [D_W-1:0]     r_dy;
    logic signed [D_W-1:0]     r_dz;
    logic signed [INC_W-1:0]   r_inc;
    t_out_item                 r_out;
    logic                      r_out_valid;

    logic signed [MUL_W-1:0]   w_mul_a;
    logic signed [MUL_W-1:0]   w_mul_b;
    logic signed [MUL_W-1:0]   w_h_op;
    logic signed [D_W-1:0]     w_xe;
    logic signed [D_W-1:0]     w_ye;
    logic signed [D_W-1:0]     w_dx;
    logic signed [D_W-1:0]     w_dy;
    logic signed [D_W-1:0]     w_psh;
    logic signed [SUM_W-1:0]   w_lo_add;

    // Upper part of a derivative, floor(d / 2^24)
    function automatic logic signed [MUL_W-1:0] hi_part(input logic signed [D_W-1:0] d);
        logic signed [D_W-1:0] t;
        begin
            t = d >>> H_FRAC;
            return MUL_W'(t);
        end
    endfunction

    // Lower 24 bits of a derivative, as a non-negative operand
    function automatic logic signed [MUL_W-1:0] lo_part(input logic signed [D_W-1:0] d);
        return $signed({{(MUL_W-H_FRAC){1'b0}}, d[H_FRAC-1:0]});
    endfunction

    // Add the increment to the old value and clamp to 32 bits
    function automatic logic signed [COORD_W-1:0] sat_add(
        input logic signed [COORD_W-1:0] c,
        input logic signed [INC_W-1:0]   hi,
        input logic signed [SUM_W-1:0]   lo
    );
        logic signed [SUM_W-1:0] s;
        begin
            s = SUM_W'(c) + SUM_W'(hi) + lo;
            if (s > SAT_HI) begin
                return COORD_W'(SAT_HI);
            end else if (s < SAT_LO) begin
                return COORD_W'(SAT_LO);
            end
            return COORD_W'(s);
        end
    endfunction

    assign w_h_op   = $signed({{(MUL_W-H_W){1'b0}}, r_h});
    assign w_xe     = D_W'(r_x);
    assign w_ye     = D_W'(r_y);
    assign w_psh    = D_W'(r_prod >>> FRAC_BITS);
    assign w_lo_add = SUM_W'(r_prod >>> H_FRAC);
    assign w_dx     = (w_ye - w_xe) * D_W'(SIGMA);
    assign w_dy     = w_xe * D_W'(RHO) - w_ye - w_psh;

    // Select the multiplier operands
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        case (i_cmd.mul_sel)
            MUL_XZ: begin
                w_mul_a = r_x;
                w_mul_b = r_z;
            end
            MUL_XY: begin
                w_mul_a = r_x;
                w_mul_b = r_y;
            end
            MUL_BZ: begin
                w_mul_a = BETA_FIX;
                w_mul_b = r_z;
            end
            MUL_HI_X: begin
                w_mul_a = w_h_op;
                w_mul_b = hi_part(r_dx);
            end
            MUL_LO_X: begin
                w_mul_a = w_h_op;
                w_mul_b = lo_part(r_dx);
            end
            MUL_HI_Y: begin
                w_mul_a = w_h_op;
                w_mul_b = hi_part(r_dy);
            end
            MUL_LO_Y: begin
                w_mul_a = w_h_op;
                w_mul_b = lo_part(r_dy);
            end
            MUL_HI_Z: begin
                w_mul_a = w_h_op;
                w_mul_b = hi_part(r_dz);
            end
            MUL_LO_Z: begin
                w_mul_a = w_h_op;
                w_mul_b = lo_part(r_dz);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // Register the product
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
    end

    // Derivatives and the high part of the increment
    always_ff @(posedge i_clk) begin
        case (i_cmd.prod_op)
            OP_DXY: begin
                r_dx <= w_dx;
                r_dy <= w_dy;
            end
            OP_DZ_SET: r_dz  <= w_psh;
            OP_DZ_SUB: r_dz  <= r_dz - w_psh;
            OP_X_HI:   r_inc <= INC_W'(r_prod);
            OP_Y_HI:   r_inc <= INC_W'(r_prod);
            OP_Z_HI:   r_inc <= INC_W'(r_prod);
            default: begin
                r_inc <= r_inc;
            end
        endcase
    end

    // Coordinate state and step size
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x <= COORD_RESET;
            r_y <= COORD_RESET;
            r_z <= COORD_RESET;
            r_h <= H_RESET;
        end else begin
            if (i_cfg_we) begin
                r_h <= i_cfg_data;
            end
            if (i_cmd.load_en) begin
                case (i_cmd.load_kind)
                    REQ_LOAD_X_STEP: r_x <= i_load_value;
                    REQ_LOAD_Y:      r_y <= i_load_value;
                    REQ_LOAD_Z:      r_z <= i_load_value;
                    default: begin
                    end
                endcase
            end
            case (i_cmd.prod_op)
                OP_X_FIN: r_x <= sat_add(r_x, r_inc, w_lo_add);
                OP_Y_FIN: r_y <= sat_add(r_y, r_inc, w_lo_add);
                OP_Z_FIN: r_z <= sat_add(r_z, r_inc, w_lo_add);
                default: begin
                end
            endcase
        end
    end

    // Output register: load a result, drop it once taken
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.x_out <= r_x;
            r_out.y_out <= r_y;
            r_out.z_out <= r_z;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_free  = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    // Never overwrite a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> (!r_out_valid || !i_out_stall))
        else $error("pending result overwritten");

endmodule

`default_nettype wire

FILE: src/lorenz_euler_step_core.sv
// Lorenz oscillator, one explicit Euler step per transaction
// (sigma 10, rho 28, beta 8/3), x, y and z held in signed Q8.24.
// Input channel i_in_valid / o_in_stall carries req_type and load_value:
// step, load x then step, load y, load z. A step returns the new x, y
// and z on the output channel o_out_valid / i_out_stall, each saturated
// to 32 bits; a load of y or z returns nothing and does not stall the input.
// i_cfg_we / i_cfg_data write the step size h (unsigned Q0.24).
// A step runs nine products through one shared 32 x 32 multiplier,
// one per cycle, then the final add; the input stays stalled until
// the result of the step is loaded into the output register.
// Reset sets x, y and z to 0.6 and h to 0.01, and empties the output.
// While the receiver stalls, the result holds in the output register;
// a further step runs to the end and then waits until that register
// is free, with the input stalled meanwhile.
`default_nettype none

module lorenz_euler_step_core (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_in_valid,
    output logic                                o_in_stall,
    input  wire les_pkg::t_in_item              i_in,
    output logic                                o_out_valid,
    input  wire logic                           i_out_stall,
    output les_pkg::t_out_item                  o_out,
    input  wire logic                           i_cfg_we,
    input  wire logic [les_pkg::H_W-1:0]        i_cfg_data
);
    import les_pkg::*;

    t_dp_cmd w_cmd;
    logic    w_out_free;

    // Sequencer
    les_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_req_type (i_in.req_type),
        .i_out_free (w_out_free),
        .o_in_stall (o_in_stall),
        .o_cmd      (w_cmd)
    );

    // Arithmetic, state and output register
    les_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .i_load_value (i_in.load_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_out_stall  (i_out_stall),
        .o_out_free   (w_out_free),
        .o_out_valid  (o_out_valid),
        .o_out        (o_out)
    );

endmodule

`default_nettype wire

FILE: bench/lorenz_euler_step_core_tb.sv
`default_nettype none

module lorenz_euler_step_core_tb;

    import les_pkg::*;

    localparam int               SETTLE_CYCLES = 24;
    localparam int               CYCLE_LIMIT   = 500000;
    localparam int               PHASE_ITEMS   = 290;
    localparam int               PROBE_COUNT   = 25;
    localparam int               Q_FRAC        = 24;
    localparam logic [23:0]      H_DEFAULT     = 24'd167772;
    localparam logic [23:0]      H_MAX         = 24'hFFFFFF;
    localparam logic [31:0]      MAX_Q         = 32'h7FFFFFFF;
    localparam logic [31:0]      MIN_Q         = 32'h80000000;
    localparam logic signed [31:0] START_COORD = 32'sd10066330;
    localparam logic signed [63:0] BETA_Q      = 64'sd44739243;
    localparam logic signed [95:0] SAT_HI      = 96'sd2147483647;
    localparam logic signed [95:0] SAT_LO      = -(96'sd2147483648);

    // One row of the directed part: optional step size write, then one transaction
    typedef struct packed {
        logic        cfg_write;
        logic [23:0] h;
        t_req_type   kind;
        logic [31:0] value;
        logic        typed;
        t_out_item   want;
    } t_probe;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    t_in_item    i_in        = '0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [23:0] i_cfg_data  = '0;
    logic        o_in_stall;
    logic        o_out_valid;
    t_out_item   o_out;

    logic        idle_on = 1'b1;

    // Trajectory state and step size as the block should hold them
    logic signed [31:0] traj_x = START_COORD;
    logic signed [31:0] traj_y = START_COORD;
    logic signed [31:0] traj_z = START_COORD;
    logic [23:0]        h_step = H_DEFAULT;

    t_out_item expected_coords [$];
    t_probe    probe_rows [0:PROBE_COUNT-1];

    int fail_count      = 0;
    int requests_sent   = 0;
    int results_checked = 0;
    int h_writes        = 0;
    int cycle_count     = 0;

    lorenz_euler_step_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Bound the run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("lorenz_euler_step_core_tb: done, errors");
            $finish;
        end
    end

    // Old value plus floor(h * derivative / 2^24), saturated to 32 bits
    function automatic logic signed [31:0] euler_update(input logic signed [31:0] old,
                                                        input logic signed [63:0] deriv);
        logic signed [95:0] d_w;
        logic signed [95:0] h_w;
        logic signed [95:0] acc;
        d_w = deriv;
        h_w = {72'd0, h_step};
        acc = ((d_w * h_w) >>> Q_FRAC) + old;
        if (acc > SAT_HI)
            return MAX_Q;
        if (acc < SAT_LO)
            return MIN_Q;
        return acc[31:0];
    endfunction

    // Apply one accepted transaction to the trajectory and queue the new point
    task automatic advance_trajectory(input t_in_item req, input logic typed,
                                      input t_out_item want);
        logic signed [63:0] ox, oy, oz, dxv, dyv, dzv;
        t_out_item          nxt;
        case (req.req_type)
            REQ_LOAD_Y: begin
                traj_y = req.load_value;
            end
            REQ_LOAD_Z: begin
                traj_z = req.load_value;
            end
            default: begin
                if (req.req_type == REQ_LOAD_X_STEP)
                    traj_x = req.load_value;
                ox  = traj_x;
                oy  = traj_y;
                oz  = traj_z;
                // all three derivatives from the old point
                dxv = 64'sd10 * (oy - ox);
                dyv = 64'sd28 * ox - oy - ((ox * oz) >>> Q_FRAC);
                dzv = ((ox * oy) >>> Q_FRAC) - ((BETA_Q * oz) >>> Q_FRAC);
                nxt.x_out = euler_update(traj_x, dxv);
                nxt.y_out = euler_update(traj_y, dyv);
                nxt.z_out = euler_update(traj_z, dzv);
                traj_x = nxt.x_out;
                traj_y = nxt.y_out;
                traj_z = nxt.z_out;
                expected_coords.push_back(typed ? want : nxt);
            end
        endcase
    endtask

    // Present one transaction after a random gap and hold it until taken
    task automatic send_request(input t_in_item req, input logic typed,
                                input t_out_item want);
        while (idle_on && $urandom_range(0, 99) < 20) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in       <= req;
        do @(posedge i_clk); while (o_in_stall);
        requests_sent++;
        advance_trajectory(req, typed, want);
    endtask

    // Drop valid, wait for every pending point, then let any load finish
    task automatic drain_results;
        i_in_valid <= 1'b0;
        while (expected_coords.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_step_size(input logic [23:0] h);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= h;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        h_step     = h;
        h_writes++;
    endtask

    // Random stall on the result side, and compare each accepted result
    always @(posedge i_clk) begin : check_results
        t_out_item want;
        if (i_rst_n) begin
            i_out_stall <= idle_on && ($urandom_range(0, 99) < 20);
            if (o_out_valid && !i_out_stall) begin
                if (expected_coords.size() == 0) begin
                    $error("result with nothing expected: x %0d y %0d z %0d",
                           o_out.x_out, o_out.y_out, o_out.z_out);
                    fail_count++;
                end else begin
                    want = expected_coords.pop_front();
                    results_checked++;
                    if (o_out.x_out !== want.x_out) begin
                        $error("x_out: expected %0d, got %0d", want.x_out, o_out.x_out);
                        fail_count++;
                    end
                    if (o_out.y_out !== want.y_out) begin
                        $error("y_out: expected %0d, got %0d", want.y_out, o_out.y_out);
                        fail_count++;
                    end
                    if (o_out.z_out !== want.z_out) begin
                        $error("z_out: expected %0d, got %0d", want.z_out, o_out.z_out);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial begin : drive_stimulus
        t_in_item    req;
        t_out_item   none;
        logic [23:0] h_pick;
        logic [31:0] val;
        int          pick;

        none = '0;
        // With h at 0 a step leaves the point unchanged; at the origin every
        // derivative is zero whatever h is
        probe_rows = '{
            '{1'b0, 24'd0,    REQ_STEP,        32'hA5A5A5A5, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, 32'h00000000, 1'b0, '0},
            '{1'b1, 24'd0,    REQ_LOAD_Y,      MAX_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Z,      MIN_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, MIN_Q,        1'b1, '{MIN_Q, MAX_Q, MIN_Q}},
            '{1'b0, 24'd0,    REQ_STEP,        32'h5A5A5A5A, 1'b1, '{MIN_Q, MAX_Q, MIN_Q}},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, MAX_Q,        1'b1, '{MAX_Q, MAX_Q, MIN_Q}},
            '{1'b0, 24'd0,    REQ_LOAD_Y,      32'h00000000, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Z,      32'h00000000, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, 32'h00000000, 1'b1, '{32'd0, 32'd0, 32'd0}},
            '{1'b1, H_MAX,    REQ_STEP,        32'hFFFFFFFF, 1'b1, '{32'd0, 32'd0, 32'd0}},
            '{1'b0, 24'd0,    REQ_LOAD_Y,      MAX_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Z,      MAX_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, MIN_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_STEP,        32'h00000000, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, MAX_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Y,      MIN_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Z,      MIN_Q,        1'b0, '0},
            '{1'b0, 24'd0,    REQ_STEP,        32'h12345678, 1'b0, '0},
            '{1'b1, 24'd1,    REQ_LOAD_X_STEP, 32'hFFFFFFFF, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_STEP,        32'h00000000, 1'b0, '0},
            '{1'b1, H_DEFAULT, REQ_LOAD_Y,     32'h00000001, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_Z,      32'hFFFFFFFF, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_LOAD_X_STEP, 32'h00999999, 1'b0, '0},
            '{1'b0, 24'd0,    REQ_STEP,        32'h00000000, 1'b0, '0}
        };

        i_rst_n <= 1'b0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part, starting from the reset point and step size
        for (int i = 0; i < PROBE_COUNT; i++) begin
            if (probe_rows[i].cfg_write)
                write_step_size(probe_rows[i].h);
            req.req_type   = probe_rows[i].kind;
            req.load_value = probe_rows[i].value;
            send_request(req, probe_rows[i].typed, probe_rows[i].want);
        end

        // Random part: mostly free-running steps, with loads to kick the trajectory
        for (int phase = 0; phase < 6; phase++) begin
            case (phase)
                0:       h_pick = H_DEFAULT;
                1:       h_pick = H_MAX;
                2:       h_pick = 24'd83886;
                3:       h_pick = 24'($urandom_range(0, 24'hFFFFFF));
                4:       h_pick = 24'd0;
                default: h_pick = 24'($urandom_range(1, 4096));
            endcase
            write_step_size(h_pick);
            // no idling on either side for the whole of one phase
            idle_on <= (phase != 2);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                pick = $urandom_range(0, 3);
                val  = $urandom();
                if (pick < 2)
                    val = {{2{val[29]}}, val[29:0]};
                else if (pick == 3)
                    val = $urandom_range(0, 1) ? MAX_Q - $urandom_range(0, 3)
                                               : MIN_Q + $urandom_range(0, 3);
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    req.req_type = REQ_STEP;
                else if (pick < 80)
                    req.req_type = REQ_LOAD_X_STEP;
                else if (pick < 90)
                    req.req_type = REQ_LOAD_Y;
                else
                    req.req_type = REQ_LOAD_Z;
                req.load_value = val;
                send_request(req, 1'b0, none);
            end
        end

        drain_results();
        $display("sent %0d transactions over %0d step size settings, extremes included",
                 requests_sent, h_writes + 1);
        $display("checked %0d stepped points, %0d mismatches", results_checked, fail_count);
        if (fail_count == 0)
            $display("lorenz_euler_step_core_tb: done, clean");
        else
            $display("lorenz_euler_step_core_tb: done, errors");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
src/les_pkg.sv
src/les_ctrl.sv
src/les_datapath.sv
src/lorenz_euler_step_core.sv
bench/lorenz_euler_step_core_tb.sv
